FILE: hdl/mi4c_pkg.sv
// ----------------------------------------------------------------------------
// mi4c_pkg
// shared types, widths and index helpers for the 4x4 adjugate inverter
// ----------------------------------------------------------------------------
package mi4c_pkg;

    localparam int ELEM_W    = 32;                // element width, signed fixed point
    localparam int FRAC_BITS = 16;                // fraction bits of an element
    localparam int SCALE_SH  = 2 * FRAC_BITS;     // numerator scale 2^(2*frac)
    localparam int CW        = 98;                // cofactor accumulator, signed
    localparam int DW        = 131;               // determinant accumulator, signed
    localparam int NW        = CW + SCALE_SH;     // scaled numerator magnitude
    localparam int DENW      = DW + SCALE_SH;     // shifted divisor
    localparam int MA_W      = 34;                // multiplier operand a, signed
    localparam int MP_W      = MA_W + ELEM_W;     // multiplier product, signed

    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // datapath operations
    typedef enum logic [4:0] {
        ST_NONE,
        ST_CLR_DET,
        ST_CLR_COF,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
        ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5,
        ST_DET_FIN,
        ST_DV_INIT,
        ST_DV_CHK,
        ST_DV_IT,
        ST_OUT_DIV,
        ST_OUT_ECHO
    } t_step;

    typedef struct packed {
        t_step       step;
        logic        wr;
        logic [3:0]  addr;
        logic        neg;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } t_stat;

    // i-th index of {0..3} with x removed
    function automatic logic [1:0] f_other(input logic [1:0] x, input logic [1:0] i);
        return (i < x) ? i : i + 2'd1;
    endfunction

    // column pick of factor i for permutation p of a 3x3 minor
    function automatic logic [1:0] f_perm(input logic [2:0] p, input logic [1:0] i);
        logic [5:0] v;
        begin
            unique case (p)
                3'd0:    v = {2'd2, 2'd1, 2'd0};
                3'd1:    v = {2'd0, 2'd2, 2'd1};
                3'd2:    v = {2'd1, 2'd0, 2'd2};
                3'd3:    v = {2'd1, 2'd2, 2'd0};
                3'd4:    v = {2'd0, 2'd1, 2'd2};
                3'd5:    v = {2'd2, 2'd0, 2'd1};
                default: v = '0;
            endcase
            unique case (i)
                2'd0:    return v[1:0];
                2'd1:    return v[3:2];
                default: return v[5:4];
            endcase
        end
    endfunction

    // odd permutations
    function automatic logic f_perm_neg(input logic [2:0] p);
        return (p >= 3'd3);
    endfunction

endpackage

FILE: hdl/mi4c_ctrl.sv
// ----------------------------------------------------------------------------
// mi4c_ctrl
// sequencer: load, cofactor terms, determinant, singular echo, divisions and result issue
// ----------------------------------------------------------------------------
module mi4c_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mi4c_pkg::t_stat i_stat,
    output mi4c_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_LOAD     = 9'b000000001,
        S_COF_CLR  = 9'b000000010,
        S_TERM     = 9'b000000100,
        S_DET      = 9'b000001000,
        S_DET_FIN  = 9'b000010000,
        S_DIV      = 9'b000100000,
        S_OUT      = 9'b001000000,
        S_ECHO     = 9'b010000000,
        S_ECHO_OUT = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_load_cnt, n_load_cnt;
    logic [3:0]  r_k, n_k;
    logic        r_ph2, n_ph2;
    logic [2:0]  r_perm, n_perm;
    logic [2:0]  r_step, n_step;
    logic [4:0]  r_bit, n_bit;

    logic [1:0]  cof_r, cof_c, idx, a_row, a_col;

    always_comb begin
        cof_r = r_ph2 ? r_k[1:0] : 2'd0;
        cof_c = r_ph2 ? r_k[3:2] : r_k[1:0];
        idx   = r_step[1:0];
        a_row = mi4c_pkg::f_other(cof_r, idx);
        a_col = mi4c_pkg::f_other(cof_c, mi4c_pkg::f_perm(r_perm, idx));
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_k        = r_k;
        n_ph2      = r_ph2;
        n_perm     = r_perm;
        n_step     = r_step;
        n_bit      = r_bit;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.step = mi4c_pkg::ST_NONE;
        o_cmd.row  = r_k[3:2];
        o_cmd.col  = r_k[1:0];
        o_cmd.last = (r_k == 4'd15);
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.addr = r_load_cnt;
                if (i_s_tvalid) begin
                    o_cmd.wr   = 1'b1;
                    n_load_cnt = r_load_cnt + 4'd1;
                    if (r_load_cnt == 4'd15) begin
                        o_cmd.step = mi4c_pkg::ST_CLR_DET;
                        n_k        = '0;
                        n_ph2      = 1'b0;
                        n_state    = S_COF_CLR;
                    end
                end
            end
            S_COF_CLR: begin
                o_cmd.step = mi4c_pkg::ST_CLR_COF;
                n_perm     = '0;
                n_step     = '0;
                n_state    = S_TERM;
            end
            S_TERM: begin
                o_cmd.addr = {a_row, a_col};
                o_cmd.neg  = mi4c_pkg::f_perm_neg(r_perm) ^ cof_r[0] ^ cof_c[0];
                unique case (r_step)
                    3'd0:    o_cmd.step = mi4c_pkg::ST_T0;
                    3'd1:    o_cmd.step = mi4c_pkg::ST_T1;
                    3'd2:    o_cmd.step = mi4c_pkg::ST_T2;
                    3'd3:    o_cmd.step = mi4c_pkg::ST_T3;
                    3'd4:    o_cmd.step = mi4c_pkg::ST_T4;
                    default: o_cmd.step = mi4c_pkg::ST_T5;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_step = '0;
                    if (r_perm == 3'd5) begin
                        n_state = r_ph2 ? S_DIV : S_DET;
                    end else begin
                        n_perm = r_perm + 3'd1;
                    end
                end
            end
            S_DET: begin
                o_cmd.addr = {2'd0, r_k[1:0]};
                unique case (r_step)
                    3'd0:    o_cmd.step = mi4c_pkg::ST_D0;
                    3'd1:    o_cmd.step = mi4c_pkg::ST_D1;
                    3'd2:    o_cmd.step = mi4c_pkg::ST_D2;
                    3'd3:    o_cmd.step = mi4c_pkg::ST_D3;
                    3'd4:    o_cmd.step = mi4c_pkg::ST_D4;
                    default: o_cmd.step = mi4c_pkg::ST_D5;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_step = '0;
                    if (r_k == 4'd3) begin
                        n_state = S_DET_FIN;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_COF_CLR;
                    end
                end
            end
            S_DET_FIN: begin
                o_cmd.step = mi4c_pkg::ST_DET_FIN;
                n_k        = '0;
                if (i_stat.det_zero) begin
                    n_state = S_ECHO;
                end else begin
                    n_ph2   = 1'b1;
                    n_state = S_COF_CLR;
                end
            end
            S_DIV: begin
                if (r_step == 3'd0) begin
                    o_cmd.step = mi4c_pkg::ST_DV_INIT;
                    n_step     = 3'd1;
                end else if (r_step == 3'd1) begin
                    o_cmd.step = mi4c_pkg::ST_DV_CHK;
                    n_step     = 3'd2;
                    n_bit      = '0;
                end else begin
                    o_cmd.step = mi4c_pkg::ST_DV_IT;
                    n_bit      = r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        n_step  = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.step = mi4c_pkg::ST_OUT_DIV;
                    if (r_k == 4'd15) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_COF_CLR;
                    end
                end
            end
            S_ECHO: begin
                o_cmd.addr = r_k;
                n_state    = S_ECHO_OUT;
            end
            S_ECHO_OUT: begin
                o_cmd.addr = r_k;
                if (i_stat.out_free) begin
                    o_cmd.step = mi4c_pkg::ST_OUT_ECHO;
                    if (r_k == 4'd15) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_ECHO;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_k        <= '0;
            r_ph2      <= 1'b0;
            r_perm     <= '0;
            r_step     <= '0;
            r_bit      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_k        <= n_k;
            r_ph2      <= n_ph2;
            r_perm     <= n_perm;
            r_step     <= n_step;
            r_bit      <= n_bit;
        end
    end

endmodule

FILE: hdl/mi4c_dp.sv
// ----------------------------------------------------------------------------
// mi4c_dp
// element store, shared multiplier, accumulators, divider and output register
// ----------------------------------------------------------------------------
module mi4c_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mi4c_pkg::t_cmd              i_cmd,
    output mi4c_pkg::t_stat             o_stat,
    input  logic [mi4c_pkg::ELEM_W-1:0] i_wdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [39:0]                 o_m_tdata,
    output logic [1:0]                  o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int EW = mi4c_pkg::ELEM_W;
    localparam int CW = mi4c_pkg::CW;
    localparam int DW = mi4c_pkg::DW;
    localparam int NW = mi4c_pkg::NW;
    localparam int DENW = mi4c_pkg::DENW;
    localparam int PW = mi4c_pkg::MP_W;

    logic [EW-1:0]          r_mem [16];
    logic [EW-1:0]          r_rd;
    logic [EW-1:0]          r_a, r_e3;
    logic [2*EW-1:0]        r_p;
    logic signed [PW-1:0]   r_prod;
    logic signed [CW-1:0]   r_cof;
    logic signed [DW-1:0]   r_det;
    logic [DW-1:0]          r_dmag;
    logic                   r_dneg;
    logic [NW-1:0]          r_rem;
    logic [DENW-1:0]        r_den;
    logic [EW-1:0]          r_q;
    logic                   r_qneg, r_big;
    logic                   r_ovalid;
    logic [EW-1:0]          r_oval;
    logic [1:0]             r_orow, r_ocol;
    logic                   r_osing, r_osat, r_olast;

    logic signed [mi4c_pkg::MA_W-1:0] mul_a;
    logic signed [EW-1:0]             mul_b;
    logic signed [PW-1:0]             mul_o;
    logic signed [CW-1:0]             cof_add;
    logic signed [DW-1:0]             det_add;
    logic [CW-1:0]                    cof_mag;
    logic                             rem_ge;
    logic [EW-1:0]                    lim, q_sgn;
    logic                             q_sat;

    // element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.addr] <= i_wdata;
        end
        r_rd <= r_mem[i_cmd.addr];
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = $signed(r_e3);
        unique case (i_cmd.step)
            mi4c_pkg::ST_T2: begin
                mul_a = {{2{r_a[EW-1]}}, r_a};
                mul_b = $signed(r_rd);
            end
            mi4c_pkg::ST_T3: begin
                mul_a = {2'b00, r_p[EW-1:0]};
                mul_b = $signed(r_rd);
            end
            mi4c_pkg::ST_T4: mul_a = {{2{r_p[2*EW-1]}}, r_p[2*EW-1:EW]};
            mi4c_pkg::ST_D2: mul_a = {2'b00, r_cof[EW-1:0]};
            mi4c_pkg::ST_D3: mul_a = {2'b00, r_cof[2*EW-1:EW]};
            mi4c_pkg::ST_D4: mul_a = r_cof[CW-1:2*EW];
            default:         mul_a = '0;
        endcase
        mul_o = mul_a * mul_b;
    end

    always_comb begin
        cof_add = (i_cmd.step == mi4c_pkg::ST_T5) ? {r_prod, {EW{1'b0}}}
                                                  : {{(CW-PW){r_prod[PW-1]}}, r_prod};
        unique case (i_cmd.step)
            mi4c_pkg::ST_D4: det_add = {{(DW-PW-EW){r_prod[PW-1]}}, r_prod, {EW{1'b0}}};
            mi4c_pkg::ST_D5: det_add = {{(DW-PW-2*EW){r_prod[PW-1]}}, r_prod,
                                        {(2*EW){1'b0}}};
            default:         det_add = {{(DW-PW){r_prod[PW-1]}}, r_prod};
        endcase
        cof_mag = r_cof[CW-1] ? CW'(-r_cof) : CW'(r_cof);
        rem_ge  = ({{(DENW-NW){1'b0}}, r_rem} >= r_den);
        lim     = r_qneg ? mi4c_pkg::ELEM_MIN : mi4c_pkg::ELEM_MAX;
        q_sat   = r_big || (r_q > lim);
        q_sgn   = r_qneg ? (~r_q + 1'b1) : r_q;
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            mi4c_pkg::ST_CLR_DET: r_det <= '0;
            mi4c_pkg::ST_CLR_COF: r_cof <= '0;
            mi4c_pkg::ST_T1:      r_a   <= r_rd;
            mi4c_pkg::ST_T2:      r_p   <= mul_o[2*EW-1:0];
            mi4c_pkg::ST_T3: begin
                r_e3   <= r_rd;
                r_prod <= mul_o;
            end
            mi4c_pkg::ST_T4: begin
                r_prod <= mul_o;
                r_cof  <= i_cmd.neg ? r_cof - cof_add : r_cof + cof_add;
            end
            mi4c_pkg::ST_T5: r_cof <= i_cmd.neg ? r_cof - cof_add : r_cof + cof_add;
            mi4c_pkg::ST_D1: r_e3  <= r_rd;
            mi4c_pkg::ST_D2: r_prod <= mul_o;
            mi4c_pkg::ST_D3, mi4c_pkg::ST_D4: begin
                r_prod <= mul_o;
                r_det  <= r_det + det_add;
            end
            mi4c_pkg::ST_D5: r_det <= r_det + det_add;
            mi4c_pkg::ST_DET_FIN: begin
                r_dneg <= r_det[DW-1];
                r_dmag <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            end
            mi4c_pkg::ST_DV_INIT: begin
                r_rem  <= {cof_mag, {mi4c_pkg::SCALE_SH{1'b0}}};
                r_qneg <= r_cof[CW-1] ^ r_dneg;
                r_den  <= {r_dmag, {mi4c_pkg::SCALE_SH{1'b0}}};
                r_q    <= '0;
            end
            mi4c_pkg::ST_DV_CHK: begin
                r_big <= rem_ge;
                r_den <= r_den >> 1;
            end
            mi4c_pkg::ST_DV_IT: begin
                if (rem_ge) begin
                    r_rem <= r_rem - r_den[NW-1:0];
                end
                r_q   <= {r_q[EW-2:0], rem_ge};
                r_den <= r_den >> 1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.step == mi4c_pkg::ST_OUT_DIV ||
                     i_cmd.step == mi4c_pkg::ST_OUT_ECHO) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == mi4c_pkg::ST_OUT_DIV) begin
            r_oval  <= q_sat ? lim : q_sgn;
            r_osat  <= q_sat;
            r_osing <= 1'b0;
        end else if (i_cmd.step == mi4c_pkg::ST_OUT_ECHO) begin
            r_oval  <= r_rd;
            r_osat  <= 1'b0;
            r_osing <= 1'b1;
        end
        if (i_cmd.step == mi4c_pkg::ST_OUT_DIV || i_cmd.step == mi4c_pkg::ST_OUT_ECHO) begin
            r_orow  <= i_cmd.row;
            r_ocol  <= i_cmd.col;
            r_olast <= i_cmd.last;
        end
    end

    assign o_stat.det_zero = (r_det == '0);
    assign o_stat.out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0000, r_ocol, r_orow, r_oval};
    assign o_m_tuser  = {r_osat, r_osing};
    assign o_m_tlast  = r_olast;

endmodule

FILE: hdl/matrix4_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor
// 4x4 fixed-point matrix inverse by the adjugate
// ----------------------------------------------------------------------------
// Takes sixteen signed Q16.16 elements in row-major order on the slave stream
// and, after the sixteenth, returns the sixteen inverse elements row-major on
// the master stream, tlast on the last one. Each cofactor is built exactly as
// six triple products of elements on one shared 34x32 multiplier, the
// determinant is the expansion along row 0, and each quotient cofactor *
// 2^32 / det comes from a restoring divider that resolves one quotient bit a
// step after a single overflow check. Quotients truncate toward zero and
// clamp to the 32-bit range with tuser[1] set. A zero determinant echoes the
// loaded matrix with tuser[0] set. Per matrix the sequence loads, builds the
// four row-0 cofactors and the determinant and, if it is nonzero, builds and
// divides each result's cofactor before issuing it (plus any output stall);
// the shared multiplier and the one-bit divider loop dominate its length. The
// input is taken only while loading.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] element_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] result_value, [33:32] result_row,
                                     // [35:34] result_col, [39:36] zero
    output logic [1:0]  o_m_tuser,   // [0] singular, [1] saturated
    output logic        o_m_tlast    // last_of_matrix
);

    mi4c_pkg::t_cmd  cmd;    // controller to datapath
    mi4c_pkg::t_stat stat;   // datapath to controller

    // sequencer
    mi4c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, element store and output register
    mi4c_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_wdata    (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // a result never carries both the singular and saturated flags
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("singular and saturated both set");

    // the last transaction of a matrix is element (3,3)
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[35:32] == 4'hF))
        else $error("tlast on wrong element");

    // new results are only created while no element is being taken
    a_no_out_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result issued during load");

endmodule
